[hw/rtl/rle8_pkg.sv]
// Package with the shared types and codes of the BMP RLE8 decoder.
package rle8_pkg;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_COLOR,
    PH_ESC,
    PH_DX,
    PH_DY,
    PH_LIT,
    PH_PAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_LIT,
    KIND_END,
    KIND_EOD
  } kind_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ADDR_W     = 25;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        length;
    logic [7:0]        color;
    logic              clipped;
  } out_item_t;

endpackage

[hw/rtl/rle8_in_if.sv]
// Valid/ready channel interface that carries compressed input items.
interface rle8_in_if;
  logic               valid;
  logic               ready;
  rle8_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rle8_out_if.sv]
// Valid/ready channel interface that carries buffer write commands.
interface rle8_out_if;
  logic                valid;
  logic                ready;
  rle8_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/bmp_rle8_decoder_top.sv]
// Top level of the BMP RLE8 decoder: parses the byte stream into buffer writes and end items.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        code_byte, restart, final_byte
//   out_ch    source     valid/ready        kind, address, length, color, clipped
//   cfg_*     input      cfg_we, no ready   cfg_index, cfg_data
//
// One item per cycle while the output register is free or taken; an accepted item
// waits in the input register, and its result, if any, is written to the output register.
// The rate is set by the single parse and address step between the two registers.
// Reset is synchronous and active low; there is no clearing pass.
// The cycle after a configuration write refreshes the stride, buffer size and row base.
// A full output register that is not taken holds the input register and, while it is full, drops in_ch.ready.
module bmp_rle8_decoder_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rle8_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rle8_pkg::CFG_DATA_W-1:0]     cfg_data,
  rle8_in_if.sink                             in_ch,
  rle8_out_if.source                          out_ch
);

  localparam int CFG_MAX = (1 << rle8_pkg::CFG_DATA_W) - 1;
  localparam int EW_MAX  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int EH_MAX  = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
  localparam int W_W     = $clog2(EW_MAX + 1);
  localparam int H_W     = $clog2(EH_MAX + 1);
  localparam int S_W     = $clog2(EW_MAX + 4);
  localparam int END_MAX = (EW_MAX + 3) * EH_MAX;
  localparam int P_W     = $clog2(END_MAX + 1);
  localparam int DS_W    = ((P_W > S_W + 8) ? P_W : S_W + 8) + 2;
  localparam int RW_W    = ((H_W > 8) ? H_W : 8) + 1;

  logic [rle8_pkg::CFG_DATA_W-1:0] width_r;
  logic [rle8_pkg::CFG_DATA_W-1:0] height_r;
  logic [1:0]                      pad_r;
  logic                            cfg_upd_r;

  logic [W_W-1:0] ew_c;
  logic [H_W-1:0] eh_c;
  logic [S_W-1:0] stride_c;

  logic [S_W-1:0] stride_r;
  logic [P_W-1:0] end_r;
  logic [H_W-1:0] eh_r;

  rle8_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             padp_r, padp_nxt;
  logic [P_W-1:0]   pos_r, pos_nxt;
  logic [H_W-1:0]   row_r, row_nxt;
  logic [P_W-1:0]   rbase_r, rbase_nxt;
  logic             fin_r, fin_nxt;

  logic                 s1_v_r;
  rle8_pkg::in_item_t   s1_r;
  logic                 out_v_r;
  rle8_pkg::out_item_t  out_r;

  logic                 res_v;
  rle8_pkg::out_item_t  res;
  logic                 out_free;
  logic                 advance;

  assign ew_c     = W_W'((width_r > rle8_pkg::CFG_DATA_W'(EW_MAX)) ?
                         rle8_pkg::CFG_DATA_W'(EW_MAX) : width_r);
  assign eh_c     = H_W'((height_r > rle8_pkg::CFG_DATA_W'(EH_MAX)) ?
                         rle8_pkg::CFG_DATA_W'(EH_MAX) : height_r);
  assign stride_c = S_W'(ew_c) + S_W'(pad_r);

  assign out_free     = !out_v_r || out_ch.ready;
  assign advance      = s1_v_r && out_free;
  assign in_ch.ready  = !s1_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  always_comb begin
    logic [7:0]      b;
    logic [P_W-1:0]  room;
    logic [7:0]      wr_n;
    logic            wr_en;
    logic [P_W:0]    wr_sum;
    logic [S_W+7:0]  dy_mul;
    logic [DS_W-1:0] dpos;
    logic [DS_W-1:0] dbase;
    logic [RW_W-1:0] rsum;
    logic [H_W:0]    r1;
    logic [P_W:0]    b1;

    b         = s1_r.code_byte;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    padp_nxt  = padp_r;
    pos_nxt   = pos_r;
    row_nxt   = row_r;
    rbase_nxt = rbase_r;
    fin_nxt   = fin_r;
    if (s1_r.restart) begin
      phase_nxt = rle8_pkg::PH_CMD;
      cnt_nxt   = 8'd0;
      padp_nxt  = 1'b0;
      pos_nxt   = '0;
      row_nxt   = '0;
      rbase_nxt = '0;
      fin_nxt   = 1'b0;
    end
    res_v  = 1'b0;
    res    = '0;
    wr_en  = 1'b0;
    wr_n   = 8'd0;
    room   = (end_r > pos_nxt) ? end_r - pos_nxt : '0;
    wr_sum = '0;
    dy_mul = (S_W + 8)'(stride_r) * (S_W + 8)'(b);
    dpos   = DS_W'(pos_nxt) + DS_W'(cnt_nxt) + DS_W'(dy_mul);
    dbase  = DS_W'(rbase_nxt) + DS_W'(dy_mul);
    rsum   = RW_W'(row_nxt) + RW_W'(b);
    r1     = (H_W + 1)'(row_nxt) + (H_W + 1)'(1);
    b1     = (P_W + 1)'(rbase_nxt) + (P_W + 1)'(stride_r);

    if (!fin_nxt) begin
      case (phase_nxt)
        rle8_pkg::PH_CMD: begin
          if (b == 8'd0) begin
            phase_nxt = rle8_pkg::PH_ESC;
          end else begin
            cnt_nxt   = b;
            phase_nxt = rle8_pkg::PH_COLOR;
          end
        end
        rle8_pkg::PH_COLOR: begin
          wr_en     = 1'b1;
          wr_n      = cnt_nxt;
          res.kind  = rle8_pkg::KIND_RUN;
          cnt_nxt   = 8'd0;
          phase_nxt = rle8_pkg::PH_CMD;
        end
        rle8_pkg::PH_ESC: begin
          if (b == rle8_pkg::ESC_EOL) begin
            if (r1 >= (H_W + 1)'(eh_r)) begin
              row_nxt   = eh_r;
              rbase_nxt = end_r;
            end else begin
              row_nxt   = H_W'(r1);
              rbase_nxt = P_W'(b1);
            end
            pos_nxt   = rbase_nxt;
            phase_nxt = rle8_pkg::PH_CMD;
          end else if (b == rle8_pkg::ESC_EOB) begin
            res_v     = 1'b1;
            res.kind  = rle8_pkg::KIND_END;
            fin_nxt   = 1'b1;
            phase_nxt = rle8_pkg::PH_CMD;
          end else if (b == rle8_pkg::ESC_DELTA) begin
            phase_nxt = rle8_pkg::PH_DX;
          end else begin
            cnt_nxt   = b;
            padp_nxt  = b[0];
            phase_nxt = rle8_pkg::PH_LIT;
          end
        end
        rle8_pkg::PH_DX: begin
          cnt_nxt   = b;
          phase_nxt = rle8_pkg::PH_DY;
        end
        rle8_pkg::PH_DY: begin
          if (rsum >= RW_W'(eh_r)) begin
            row_nxt   = eh_r;
            rbase_nxt = end_r;
          end else begin
            row_nxt   = H_W'(rsum);
            rbase_nxt = P_W'(dbase);
          end
          pos_nxt   = (dpos > DS_W'(end_r)) ? end_r : P_W'(dpos);
          cnt_nxt   = 8'd0;
          phase_nxt = rle8_pkg::PH_CMD;
        end
        rle8_pkg::PH_LIT: begin
          wr_en    = 1'b1;
          wr_n     = 8'd1;
          res.kind = rle8_pkg::KIND_LIT;
          cnt_nxt  = cnt_nxt - 8'd1;
          if (cnt_nxt == 8'd0) begin
            phase_nxt = padp_nxt ? rle8_pkg::PH_PAD : rle8_pkg::PH_CMD;
          end
        end
        default: begin
          padp_nxt  = 1'b0;
          phase_nxt = rle8_pkg::PH_CMD;
        end
      endcase

      if (wr_en) begin
        res_v       = 1'b1;
        res.address = rle8_pkg::ADDR_W'(pos_nxt);
        res.color   = b;
        if (P_W'(wr_n) > room) begin
          res.length  = room[7:0];
          res.clipped = 1'b1;
        end else begin
          res.length  = wr_n;
          res.clipped = 1'b0;
        end
        wr_sum  = (P_W + 1)'(pos_nxt) + (P_W + 1)'(wr_n);
        pos_nxt = (wr_sum > (P_W + 1)'(end_r)) ? end_r : P_W'(wr_sum);
      end

      if (s1_r.final_byte && !fin_nxt) begin
        fin_nxt = 1'b1;
        if (!res_v) begin
          res_v    = 1'b1;
          res      = '0;
          res.kind = rle8_pkg::KIND_EOD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rle8_pkg::CFG_DATA_W'(1);
      height_r  <= rle8_pkg::CFG_DATA_W'(1);
      pad_r     <= 2'd0;
      cfg_upd_r <= 1'b0;
      stride_r  <= S_W'(1);
      end_r     <= P_W'(1);
      eh_r      <= H_W'(1);
      phase_r   <= rle8_pkg::PH_CMD;
      cnt_r     <= 8'd0;
      padp_r    <= 1'b0;
      pos_r     <= '0;
      row_r     <= '0;
      rbase_r   <= '0;
      fin_r     <= 1'b0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      cfg_upd_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          rle8_pkg::REG_WIDTH:   width_r  <= cfg_data;
          rle8_pkg::REG_HEIGHT:  height_r <= cfg_data;
          rle8_pkg::REG_PADDING: pad_r    <= cfg_data[1:0];
          default: ;
        endcase
      end

      if (cfg_upd_r) begin
        stride_r <= stride_c;
        eh_r     <= eh_c;
        end_r    <= P_W'(P_W'(stride_c) * P_W'(eh_c));
        rbase_r  <= P_W'(P_W'(row_r) * P_W'(stride_c));
      end else if (advance) begin
        rbase_r <= rbase_nxt;
      end

      if (advance) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        padp_r  <= padp_nxt;
        pos_r   <= pos_nxt;
        row_r   <= row_nxt;
        fin_r   <= fin_nxt;
      end

      if (in_ch.valid && in_ch.ready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end

      if (advance && res_v) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
    if (advance && res_v) begin
      out_r <= res;
    end
  end

endmodule
